[hw/rtl/rtp_pkg.sv]
// Types, constants and arctangent table shared by the rectangular to polar converter.
`timescale 1ns / 1ps

package rtp_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int GUARD_BITS  = 16;
   localparam int DATA_WIDTH  = 35;
   localparam int ANGLE_WIDTH = 32;
   localparam int TABLE_DEPTH = 32;
   localparam int INDEX_WIDTH = 5;
   localparam int HI_WIDTH    = DATA_WIDTH - ANGLE_WIDTH;

   localparam logic [ANGLE_WIDTH-1:0] INV_GAIN = 32'd2608131496;
   localparam logic [ANGLE_WIDTH-1:0] HALF_TURN = 32'h8000_0000;

   localparam logic [ANGLE_WIDTH-1:0] ATAN_TABLE [TABLE_DEPTH] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x_coord;
      logic signed [COORD_WIDTH-1:0] y_coord;
      logic                          last;
   } rtp_req_type;

   typedef struct packed {
      logic        [COORD_WIDTH-1:0] magnitude;
      logic signed [COORD_WIDTH-1:0] angle;
      logic                          last_out;
   } rtp_rsp_type;

   // one point on its way through the rotation stages
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0]  x;
      logic signed [DATA_WIDTH-1:0]  y;
      logic        [ANGLE_WIDTH-1:0] z;
      logic                          origin;
      logic                          last;
   } rtp_lane_type;

endpackage

[hw/rtl/rtp_stage.sv]
// One vectoring micro-rotation stage with its own valid bit and register.
`timescale 1ns / 1ps

module rtp_stage #(
   parameter int SHIFT = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   input  rtp_pkg::rtp_lane_type up_lane,
   output logic                 up_ready,
   output logic                 down_valid,
   output rtp_pkg::rtp_lane_type down_lane,
   input  logic                 down_ready
);
   import rtp_pkg::*;

   localparam logic [INDEX_WIDTH-1:0] TAB_INDEX = INDEX_WIDTH'(SHIFT);
   localparam logic [ANGLE_WIDTH-1:0] STEP_ANGLE = ATAN_TABLE[TAB_INDEX];

   logic                         valid_ff;
   logic                         valid_in;
   rtp_lane_type                 lane_ff;
   rtp_lane_type                 lane_in;
   logic signed [DATA_WIDTH-1:0] dx;
   logic signed [DATA_WIDTH-1:0] dy;

   assign up_ready = !valid_ff || down_ready;
   assign dx = up_lane.y >>> SHIFT;
   assign dy = up_lane.x >>> SHIFT;

   always_comb begin
      lane_in = up_lane;
      // turn towards the x axis: the sign of y picks the direction
      if (!up_lane.y[DATA_WIDTH-1]) begin
         lane_in.x = up_lane.x + dx;
         lane_in.y = up_lane.y - dy;
         lane_in.z = up_lane.z + STEP_ANGLE;
      end else begin
         lane_in.x = up_lane.x - dx;
         lane_in.y = up_lane.y + dy;
         lane_in.z = up_lane.z - STEP_ANGLE;
      end
      valid_in = up_ready ? up_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         lane_ff <= lane_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_lane  = lane_ff;

endmodule

[hw/rtl/rect_to_polar_converter.sv]
// Top level: CORDIC vectoring pipeline from rectangular point to magnitude and angle.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  rtp_req_type: x_coord, y_coord, last
//   rsp_     out        rsp_valid/rsp_stall  rtp_rsp_type: magnitude, angle, last_out
//
// One point enters per cycle while the output is not stalled; the pipeline holds an input stage
// for the half-turn pre-rotation, one stage per micro-rotation, a stage for the
// split gain product and the output register.
// Reset clears the valid bits only; data registers carry no reset.
// A stalled result holds the output register; earlier stages keep filling
// until each holds an item, so empty slots are squeezed out and nothing is lost.
`timescale 1ns / 1ps

module rect_to_polar_converter #(
   parameter int ITERATIONS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  rtp_pkg::rtp_req_type req_item,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rtp_pkg::rtp_rsp_type rsp_item
);
   import rtp_pkg::*;

   localparam int EXT_WIDTH = DATA_WIDTH - COORD_WIDTH;
   localparam int LO_PROD_WIDTH = 2 * ANGLE_WIDTH;
   localparam int HI_PROD_WIDTH = HI_WIDTH + ANGLE_WIDTH;
   localparam int SUM_WIDTH = HI_PROD_WIDTH + 2;
   localparam int MAG_FULL_WIDTH = SUM_WIDTH - GUARD_BITS;
   localparam logic [ANGLE_WIDTH-1:0] ANGLE_ROUND = ANGLE_WIDTH'(1) <<
      (ANGLE_WIDTH - COORD_WIDTH - 1);
   localparam logic [SUM_WIDTH-1:0] MAG_ROUND = SUM_WIDTH'(1) << (GUARD_BITS - 1);

   // input stage
   logic                         pre_valid_ff;
   logic                         pre_valid_in;
   logic                         pre_ready;
   rtp_lane_type                 pre_lane_ff;
   rtp_lane_type                 pre_lane_in;
   logic signed [DATA_WIDTH-1:0] x_ext;
   logic signed [DATA_WIDTH-1:0] y_ext;

   // rotation chain
   logic                         chain_valid [ITERATIONS+1];
   logic                         chain_ready [ITERATIONS+1];
   rtp_lane_type                 chain_lane  [ITERATIONS+1];

   // product stage
   logic                         mul_valid_ff;
   logic                         mul_valid_in;
   logic                         mul_ready;
   logic [LO_PROD_WIDTH-1:0]     lo_prod_ff;
   logic [HI_PROD_WIDTH-1:0]     hi_prod_ff;
   logic signed [COORD_WIDTH-1:0] angle_ff;
   logic                         origin_ff;
   logic                         last_ff;
   logic [ANGLE_WIDTH-1:0]       angle_sum;

   // output stage
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic                         out_ready;
   rtp_rsp_type                  rsp_item_ff;
   rtp_rsp_type                  rsp_item_in;
   logic [SUM_WIDTH-1:0]         mag_sum;
   logic [MAG_FULL_WIDTH-1:0]    mag_full;

   // ---------------- input stage ----------------
   assign pre_ready = !pre_valid_ff || chain_ready[0];
   assign req_stall = !pre_ready;

   assign x_ext = {{EXT_WIDTH{req_item.x_coord[COORD_WIDTH-1]}}, req_item.x_coord};
   assign y_ext = {{EXT_WIDTH{req_item.y_coord[COORD_WIDTH-1]}}, req_item.y_coord};

   always_comb begin
      pre_lane_in.origin = (req_item.x_coord == '0) && (req_item.y_coord == '0);
      pre_lane_in.last   = req_item.last;
      // left half plane: turn by pi first
      if (req_item.x_coord[COORD_WIDTH-1]) begin
         pre_lane_in.x = (-x_ext) <<< GUARD_BITS;
         pre_lane_in.y = (-y_ext) <<< GUARD_BITS;
         pre_lane_in.z = HALF_TURN;
      end else begin
         pre_lane_in.x = x_ext <<< GUARD_BITS;
         pre_lane_in.y = y_ext <<< GUARD_BITS;
         pre_lane_in.z = '0;
      end
      pre_valid_in = pre_ready ? req_valid : pre_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else begin
         pre_valid_ff <= pre_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pre_ready && req_valid) begin
         pre_lane_ff <= pre_lane_in;
      end
   end

   assign chain_valid[0] = pre_valid_ff;
   assign chain_lane[0]  = pre_lane_ff;

   // ---------------- rotation chain ----------------
   for (genvar i = 0; i < ITERATIONS; i++) begin : g_stage
      rtp_stage #(
         .SHIFT(i)
      ) u_stage (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (chain_valid[i]),
         .up_lane    (chain_lane[i]),
         .up_ready   (chain_ready[i]),
         .down_valid (chain_valid[i+1]),
         .down_lane  (chain_lane[i+1]),
         .down_ready (chain_ready[i+1])
      );
   end

   assign chain_ready[ITERATIONS] = mul_ready;

   // ---------------- gain product stage ----------------
   assign mul_ready = !mul_valid_ff || out_ready;
   assign mul_valid_in = mul_ready ? chain_valid[ITERATIONS] : mul_valid_ff;
   assign angle_sum = chain_lane[ITERATIONS].z + ANGLE_ROUND;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
      end
   end

   // x stays positive; split it into a 32-bit low part and a short high part
   always_ff @(posedge clock) begin
      if (mul_ready && chain_valid[ITERATIONS]) begin
         lo_prod_ff <= LO_PROD_WIDTH'(chain_lane[ITERATIONS].x[ANGLE_WIDTH-1:0]) *
                       LO_PROD_WIDTH'(INV_GAIN);
         hi_prod_ff <= HI_PROD_WIDTH'(chain_lane[ITERATIONS].x[DATA_WIDTH-1:ANGLE_WIDTH]) *
                       HI_PROD_WIDTH'(INV_GAIN);
         angle_ff   <= chain_lane[ITERATIONS].origin ? '0 :
                       angle_sum[ANGLE_WIDTH-1 -: COORD_WIDTH];
         origin_ff  <= chain_lane[ITERATIONS].origin;
         last_ff    <= chain_lane[ITERATIONS].last;
      end
   end

   // ---------------- output stage ----------------
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = out_ready ? mul_valid_ff : rsp_valid_ff;

   assign mag_sum = SUM_WIDTH'(hi_prod_ff) +
                    SUM_WIDTH'(lo_prod_ff[LO_PROD_WIDTH-1:ANGLE_WIDTH]) + MAG_ROUND;
   assign mag_full = mag_sum[SUM_WIDTH-1:GUARD_BITS];

   always_comb begin
      rsp_item_in.angle    = angle_ff;
      rsp_item_in.last_out = last_ff;
      if (origin_ff) begin
         rsp_item_in.magnitude = '0;
      end else if (|mag_full[MAG_FULL_WIDTH-1:COORD_WIDTH]) begin
         rsp_item_in.magnitude = '1;
      end else begin
         rsp_item_in.magnitude = mag_full[COORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the item while stalled
   always_ff @(posedge clock) begin
      if (out_ready && mul_valid_ff) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
